>>> rtl/sm3_pkg.sv
// shared types, constants and functions of the sm3 hash engine
`timescale 1ns / 1ps

package sm3_pkg;

    localparam int LENGTH_WIDTH_DEF = 64;
    localparam int QUEUE_DEPTH_DEF  = 2;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } t_digest;

    typedef logic [0:7][31:0] t_chain;

    typedef struct packed {
        logic              blk_last;
        logic [15:0][31:0] words;
    } t_block;

    localparam t_chain SM3_IV = {
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    localparam logic [31:0] SM3_T_LO  = 32'h79CC4519;
    localparam logic [31:0] SM3_T_HI  = 32'h7A879D8A;
    localparam logic [7:0]  SM3_PAD   = 8'h80;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        rotl32 = (x << n) | (x >> (6'd32 - {1'b0, n}));
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        perm0 = x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        perm1 = x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

    // round constant already rotated by the round number
    function automatic logic [31:0] round_const(input logic [5:0] j);
        round_const = rotl32((j[5:4] == 2'd0) ? SM3_T_LO : SM3_T_HI, j[4:0]);
    endfunction

endpackage

>>> rtl/sm3_front.sv
// byte packer and padder: builds 64-byte blocks from message words
`timescale 1ns / 1ps

module sm3_front #(
    parameter int LENGTH_WIDTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sm3_pkg::t_in_word i_item,
    output logic            o_full,
    output logic            o_q_push,
    output sm3_pkg::t_block o_q_block,
    input  logic            i_q_full
);
    import sm3_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DATA = 3'd1;
    localparam logic [2:0] ST_PAD  = 3'd2;
    localparam logic [2:0] ST_ZERO = 3'd3;
    localparam logic [2:0] ST_LEN  = 3'd4;

    logic [2:0]              r_state, n_state;
    logic [31:0]             r_data, n_data;
    logic [2:0]              r_cnt, n_cnt;
    logic                    r_last, n_last;
    logic [5:0]              r_fill, n_fill;
    logic [LENGTH_WIDTH-1:0] r_bits, n_bits;
    logic [15:0][31:0]       r_buf, n_buf;

    logic        byte_en;
    logic        go;
    logic [7:0]  byte_val;
    logic [2:0]  in_cnt;
    logic [63:0] len64;

    assign len64   = 64'(r_bits);
    assign byte_en = (r_state != ST_IDLE);
    assign go      = byte_en && !((r_fill == 6'd63) && i_q_full);
    assign o_full  = (r_state != ST_IDLE);
    assign in_cnt  = (i_item.byte_count > 3'd4) ? 3'd4 : i_item.byte_count;

    always_comb begin
        n_state  = r_state;
        n_data   = r_data;
        n_cnt    = r_cnt;
        n_last   = r_last;
        n_fill   = r_fill;
        n_bits   = r_bits;
        n_buf    = r_buf;
        byte_val = 8'd0;
        o_q_push = 1'b0;

        unique case (r_state)
            ST_IDLE: byte_val = 8'd0;
            ST_DATA: byte_val = r_data[31:24];
            ST_PAD:  byte_val = SM3_PAD;
            ST_ZERO: byte_val = 8'd0;
            ST_LEN:  byte_val = len64[{~r_cnt, 3'b000} +: 8];
            default: byte_val = 8'd0;
        endcase

        if (r_state == ST_IDLE) begin
            if (i_push) begin
                n_data = i_item.data_word;
                n_cnt  = in_cnt;
                n_last = i_item.last_word;
                n_bits = r_bits + LENGTH_WIDTH'({in_cnt, 3'b000});
                if (in_cnt != 3'd0) begin
                    n_state = ST_DATA;
                end else if (i_item.last_word) begin
                    n_state = ST_PAD;
                end
            end
        end else if (go) begin
            n_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] = byte_val;
            n_fill   = r_fill + 6'd1;
            o_q_push = (r_fill == 6'd63);
            case (r_state)
                ST_DATA: begin
                    n_data = r_data << 8;
                    n_cnt  = r_cnt - 3'd1;
                    if (r_cnt == 3'd1) begin
                        n_state = r_last ? ST_PAD : ST_IDLE;
                    end
                end
                ST_PAD, ST_ZERO: begin
                    if (n_fill == 6'd56) begin
                        n_state = ST_LEN;
                        n_cnt   = 3'd0;
                    end else begin
                        n_state = ST_ZERO;
                    end
                end
                ST_LEN: begin
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        n_state = ST_IDLE;
                        n_bits  = '0;
                    end
                end
                default: n_state = ST_IDLE;
            endcase
        end
    end

    assign o_q_block.blk_last = (r_state == ST_LEN) && (r_cnt == 3'd7);
    assign o_q_block.words    = n_buf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_bits  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_bits  <= n_bits;
        end
        r_data <= n_data;
        r_cnt  <= n_cnt;
        r_last <= n_last;
        r_buf  <= n_buf;
    end

endmodule

>>> rtl/sm3_blk_queue.sv
// short queue of full blocks between packer and compression core
`timescale 1ns / 1ps

module sm3_blk_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sm3_pkg::t_block i_block,
    output logic            o_full,
    input  logic            i_pop,
    output sm3_pkg::t_block o_block,
    output logic            o_empty
);
    import sm3_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_block        r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    logic do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_block = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (do_push) begin
            r_mem[r_wp] <= i_block;
        end
    end

endmodule

>>> rtl/sm3_core.sv
// sm3 compression core: message expansion, 64 rounds, digest output
`timescale 1ns / 1ps

module sm3_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sm3_pkg::t_block i_q_block,
    input  logic            i_q_empty,
    output logic            o_q_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output sm3_pkg::t_digest o_result
);
    import sm3_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ROUND  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]        r_state;
    logic [5:0]        r_round;
    logic [15:0][31:0] r_w;
    t_chain            r_v;
    t_chain            r_chain;
    logic              r_final;
    t_chain            r_dig;
    logic              r_dvalid;
    logic [2:0]        r_didx;

    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, wnew;
    t_chain      v_next;
    t_chain      chain_new;
    logic        low_rounds;

    assign low_rounds = (r_round[5:4] == 2'd0);
    assign a12  = rotl32(r_v[0], 5'd12);
    assign ss1  = rotl32(a12 + r_v[4] + round_const(r_round), 5'd7);
    assign ss2  = ss1 ^ a12;
    assign ff   = low_rounds ? (r_v[0] ^ r_v[1] ^ r_v[2])
                             : ((r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]));
    assign gg   = low_rounds ? (r_v[4] ^ r_v[5] ^ r_v[6])
                             : ((r_v[4] & r_v[5]) | (~r_v[4] & r_v[6]));
    assign tt1  = ff + r_v[3] + ss2 + (r_w[0] ^ r_w[4]);
    assign tt2  = gg + r_v[7] + ss1 + r_w[0];
    // next expanded word w[j+16]
    assign wnew = perm1(r_w[0] ^ r_w[7] ^ rotl32(r_w[13], 5'd15))
                  ^ rotl32(r_w[3], 5'd7) ^ r_w[10];

    assign v_next = {tt1, r_v[0], rotl32(r_v[1], 5'd9), r_v[2],
                     perm0(tt2), r_v[4], rotl32(r_v[5], 5'd19), r_v[6]};
    assign chain_new = r_chain ^ r_v;

    assign o_q_pop = (r_state == ST_IDLE) && !i_q_empty;
    assign o_empty = !r_dvalid;
    assign o_result.digest_word = r_dig[r_didx];
    assign o_result.digest_last = (r_didx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_round  <= '0;
            r_chain  <= SM3_IV;
            r_dvalid <= 1'b0;
            r_didx   <= '0;
        end else begin
            if (i_pop && r_dvalid) begin
                r_didx <= r_didx + 3'd1;
                if (r_didx == 3'd7) begin
                    r_dvalid <= 1'b0;
                end
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_w     <= i_q_block.words;
                        r_v     <= r_chain;
                        r_final <= i_q_block.blk_last;
                        r_round <= '0;
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    r_v     <= v_next;
                    r_w     <= {wnew, r_w[15:1]};
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    // final block waits until the previous digest is drained
                    if (!(r_final && r_dvalid)) begin
                        r_state <= ST_IDLE;
                        if (r_final) begin
                            r_dig    <= chain_new;
                            r_dvalid <= 1'b1;
                            r_didx   <= '0;
                            r_chain  <= SM3_IV;
                        end else begin
                            r_chain  <= chain_new;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_round == 6'd63) |=> (r_state == ST_FINISH))
        else $error("round counter did not end the block");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_dvalid |-> (r_didx == 3'd0))
        else $error("digest index not at word 0 while empty");

    a_digest_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_final && !r_dvalid) |=> (r_dvalid && r_chain == SM3_IV))
        else $error("digest not loaded or chain not restarted");

endmodule

>>> rtl/sm3_hash_engine_unit.sv
// top level of the sm3 hash engine
// usage:
//   input side is a queue: drive i_item and i_push; a word is taken at an edge
//   with i_push high and o_full low. each word carries up to four big-endian
//   bytes, a byte count (above four counts as four) and a last mark.
//   result side is a queue: o_result holds the oldest digest word while o_empty
//   is low; it is taken at an edge with i_pop high. eight words per message,
//   word 0 first, digest_last set on the eighth.
// flow:
//   the packer takes a word, then moves one byte per cycle unless the block
//   queue is full when a block's last byte is due; o_full stays high until the
//   word's bytes are moved. the core runs one round per cycle, and a two-block
//   queue lets packing and compression stall on their own.
//   after the last word, the packer adds padding and the length, holding
//   o_full meanwhile, and the digest appears once the final block has been
//   compressed.
// stalls: if the digest is not popped, the next message's final block waits in
//   the core and the block queue fills, after which o_full holds off input.
// reset: i_rst_n low at an edge clears the length, fill, queues and restores
//   the initial chaining value.
`timescale 1ns / 1ps

module sm3_hash_engine_unit #(
    parameter int LENGTH_WIDTH = sm3_pkg::LENGTH_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sm3_pkg::t_in_word i_item,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output sm3_pkg::t_digest o_result
);
    import sm3_pkg::*;

    logic   q_push, q_full, q_pop, q_empty;
    t_block q_in, q_out;

    sm3_front #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_item   (i_item),
        .o_full   (o_full),
        .o_q_push (q_push),
        .o_q_block(q_in),
        .i_q_full (q_full)
    );

    sm3_blk_queue #(
        .DEPTH(QUEUE_DEPTH_DEF)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_block(q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_block(q_out),
        .o_empty(q_empty)
    );

    sm3_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_block(q_out),
        .i_q_empty(q_empty),
        .o_q_pop  (q_pop),
        .i_pop    (i_pop),
        .o_empty  (o_empty),
        .o_result (o_result)
    );

endmodule
